/* rtl/pta_pkg.sv */
package pta_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_INS_STATIC   = 3'd0,
        OP_INS_MOVABLE  = 3'd1,
        OP_RECT         = 3'd2,
        OP_CIRCLE       = 3'd3,
        OP_CIRCLE_ANGLE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } t_bk_state;

    typedef struct packed {
        t_op                op;
        logic        [15:0] id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] angle;
        logic signed [15:0] xmin;
        logic signed [15:0] xmax;
        logic signed [15:0] ymin;
        logic signed [15:0] ymax;
        logic        [15:0] radius;
        logic signed [15:0] amin;
        logic signed [15:0] amax;
    } t_cmd;

    typedef struct packed {
        logic               kind;
        logic        [15:0] id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] angle;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [15:0] id;
        logic        last;
    } t_result;

endpackage

/* rtl/point_table_area_query.sv */
// channel  | handshake         | fields
// ---------+-------------------+---------------------------------------------
// request  | push / full       | i_operation, i_obj_id, i_point_x/y, ...
// result   | empty / pop       | o_status, o_match_id, o_last_result
//
// Insert: one request per cycle sustained while the result queue has room.
// Query: one load step, entry count + 1 scan steps (one table memory read per
// cycle while the result queue has room), then the compare/square pipeline drains.
// Reset empties the table by zeroing the count; no clearing pass.
// A full result queue freezes the scan; a busy scan backs up the 2-deep
// request queue, then full rises.
module point_table_area_query #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic        [2:0]  i_operation,
    input  logic        [15:0] i_obj_id,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_obj_angle,
    input  logic signed [15:0] i_area_xmin,
    input  logic signed [15:0] i_area_xmax,
    input  logic signed [15:0] i_area_ymin,
    input  logic signed [15:0] i_area_ymax,
    input  logic        [15:0] i_radius,
    input  logic signed [15:0] i_angle_min,
    input  logic signed [15:0] i_angle_max,
    output logic               empty,
    input  logic               pop,
    output logic        [1:0]  o_status,
    output logic        [15:0] o_match_id,
    output logic               o_last_result
);

    pta_pkg::t_cmd    w_in;
    pta_pkg::t_cmd    w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_pop;
    pta_pkg::t_result w_res;
    logic             w_res_push;
    logic             w_res_full;
    pta_pkg::t_result w_out;

    assign w_in.op     = pta_pkg::t_op'(i_operation);
    assign w_in.id     = i_obj_id;
    assign w_in.x      = i_point_x;
    assign w_in.y      = i_point_y;
    assign w_in.angle  = i_obj_angle;
    assign w_in.xmin   = i_area_xmin;
    assign w_in.xmax   = i_area_xmax;
    assign w_in.ymin   = i_area_ymin;
    assign w_in.ymax   = i_area_ymax;
    assign w_in.radius = i_radius;
    assign w_in.amin   = i_angle_min;
    assign w_in.amax   = i_angle_max;

    pta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (w_in),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    pta_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    pta_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out)
    );

    assign o_status      = w_out.status;
    assign o_match_id    = w_out.id;
    assign o_last_result = w_out.last;

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != pta_pkg::ST_MATCH) |-> o_last_result)
        else $error("non-match result not marked last");

    a_single_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != pta_pkg::ST_MATCH) |-> (o_match_id == 16'd0))
        else $error("non-match result carries an id");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("request popped from empty queue");

endmodule

/* rtl/pta_front.sv */
module pta_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pta_pkg::t_cmd i_cmd,
    output logic          o_full,
    output pta_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    localparam int QD = 2;

    pta_pkg::t_cmd r_q [QD];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_known;
    logic          w_enq;
    logic          w_deq;

    // unknown codes are taken and dropped here
    always_comb begin
        w_known = 1'b0;
        case (i_cmd.op) inside
            pta_pkg::OP_INS_STATIC, pta_pkg::OP_INS_MOVABLE, pta_pkg::OP_RECT,
            pta_pkg::OP_CIRCLE, pta_pkg::OP_CIRCLE_ANGLE: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == 2'(QD));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_enq       = i_push && !o_full && w_known;
    assign w_deq       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_enq) begin
                r_wp <= ~r_wp;
            end
            if (w_deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_enq) - 2'(w_deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/pta_back.sv */
module pta_back #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pta_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    output pta_pkg::t_result o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [15:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic [16:0] d;
        logic [16:0] nd;
        d  = {a[15], a} - {b[15], b};
        nd = 17'd0 - d;
        return d[16] ? nd[15:0] : d[15:0];
    endfunction

    pta_pkg::t_bk_state r_state, n_state;
    pta_pkg::t_entry    r_mem [CAPACITY];
    pta_pkg::t_entry    r_rd;
    pta_pkg::t_cmd      r_q;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_scan;
    logic [31:0]        r_r2;

    logic               r_s1_v, r_s1_t;
    logic               r_s2_v, r_s2_t, r_s2_kind, r_s2_rect, r_s2_ang;
    logic [15:0]        r_s2_id, r_s2_dx, r_s2_dy;
    logic               r_s3_v, r_s3_t, r_s3_kind, r_s3_rect, r_s3_ang;
    logic [15:0]        r_s3_id;
    logic [31:0]        r_s3_dx2, r_s3_dy2;

    logic               r_pend_v;
    logic [15:0]        r_pend_id;
    logic [pta_pkg::NRES_W-1:0] r_nres;
    logic               r_stop;

    logic               w_adv;
    logic               w_issue;
    logic               w_issue_term;
    logic               w_ins_write;
    logic               w_load;
    logic               w_dist_ok;
    logic               w_hit;
    logic               w_take;
    logic               w_is_rect;
    logic               w_is_angle;
    pta_pkg::t_entry    w_new;

    assign w_adv      = !i_res_full;
    assign w_is_rect  = (r_q.op == pta_pkg::OP_RECT);
    assign w_is_angle = (r_q.op == pta_pkg::OP_CIRCLE_ANGLE);
    assign w_dist_ok  = ({1'b0, r_s3_dx2} + {1'b0, r_s3_dy2}) <= {1'b0, r_r2};
    assign w_hit      = r_s3_kind &&
                        (r_s3_rect || (!w_is_rect && w_dist_ok && (!w_is_angle || r_s3_ang)));
    assign w_take     = w_adv && r_s3_v && !r_s3_t && w_hit && !r_stop;

    assign w_new.kind  = (i_cmd.op == pta_pkg::OP_INS_MOVABLE);
    assign w_new.id    = i_cmd.id;
    assign w_new.x     = i_cmd.x;
    assign w_new.y     = i_cmd.y;
    assign w_new.angle = i_cmd.angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pta_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res.status = pta_pkg::ST_INSERTED;
        o_res.id     = 16'd0;
        o_res.last   = 1'b1;
        w_issue      = 1'b0;
        w_issue_term = 1'b0;
        w_ins_write  = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            pta_pkg::BK_IDLE: begin
                if (i_cmd_valid && w_adv) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op) inside
                        pta_pkg::OP_INS_STATIC, pta_pkg::OP_INS_MOVABLE: begin
                            o_res_push = 1'b1;
                            if (r_count < CW'(CAPACITY)) begin
                                w_ins_write = 1'b1;
                            end else begin
                                o_res.status = pta_pkg::ST_FULL;
                            end
                        end
                        pta_pkg::OP_RECT, pta_pkg::OP_CIRCLE, pta_pkg::OP_CIRCLE_ANGLE: begin
                            w_load  = 1'b1;
                            n_state = pta_pkg::BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            pta_pkg::BK_SCAN: begin
                if (w_adv) begin
                    w_issue = 1'b1;
                    if (r_scan == r_count) begin
                        w_issue_term = 1'b1;
                        n_state      = pta_pkg::BK_DRAIN;
                    end
                end
            end
            pta_pkg::BK_DRAIN: begin
                if (w_adv && r_s3_v && r_s3_t) begin
                    n_state = pta_pkg::BK_IDLE;
                end
            end
            default: n_state = pta_pkg::BK_IDLE;
        endcase

        // a match is held back until the next one or the end of the scan marks it
        if (w_adv && r_s3_v) begin
            if (r_s3_t) begin
                o_res_push   = 1'b1;
                o_res.status = r_pend_v ? pta_pkg::ST_MATCH : pta_pkg::ST_NOMATCH;
                o_res.id     = r_pend_v ? r_pend_id : 16'd0;
                o_res.last   = 1'b1;
            end else if (w_take && r_pend_v) begin
                o_res_push   = 1'b1;
                o_res.status = pta_pkg::ST_MATCH;
                o_res.id     = r_pend_id;
                o_res.last   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_scan   <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_pend_v <= 1'b0;
            r_nres   <= '0;
            r_stop   <= 1'b0;
        end else begin
            if (w_ins_write) begin
                r_count <= r_count + CW'(1);
            end
            if (w_load) begin
                r_scan   <= '0;
                r_pend_v <= 1'b0;
                r_nres   <= '0;
                r_stop   <= 1'b0;
            end else if (w_issue && !w_issue_term) begin
                r_scan <= r_scan + CW'(1);
            end
            if (w_adv) begin
                r_s1_v <= w_issue;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                if (r_s3_v && r_s3_t) begin
                    r_pend_v <= 1'b0;
                end else if (w_take) begin
                    r_pend_v <= 1'b1;
                    r_nres   <= r_nres + pta_pkg::NRES_W'(1);
                    if (r_nres == pta_pkg::NRES_W'(pta_pkg::MAX_RESULTS - 1)) begin
                        r_stop <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_write) begin
            r_mem[r_count[AW-1:0]] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd <= r_mem[r_scan[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_q  <= i_cmd;
            r_r2 <= i_cmd.radius * i_cmd.radius;
        end
        if (w_take) begin
            r_pend_id <= r_s3_id;
        end
        if (w_adv) begin
            r_s1_t    <= w_issue_term;
            r_s2_t    <= r_s1_t;
            r_s2_id   <= r_rd.id;
            r_s2_kind <= (r_rd.kind == !w_is_rect);
            r_s2_rect <= w_is_rect &&
                         (r_rd.x >= r_q.xmin) && (r_rd.x <= r_q.xmax) &&
                         (r_rd.y >= r_q.ymin) && (r_rd.y <= r_q.ymax);
            r_s2_ang  <= (r_rd.angle > r_q.amin) && (r_rd.angle < r_q.amax);
            r_s2_dx   <= abs_diff(r_rd.x, r_q.x);
            r_s2_dy   <= abs_diff(r_rd.y, r_q.y);
            r_s3_t    <= r_s2_t;
            r_s3_id   <= r_s2_id;
            r_s3_kind <= r_s2_kind;
            r_s3_rect <= r_s2_rect;
            r_s3_ang  <= r_s2_ang;
            r_s3_dx2  <= r_s2_dx * r_s2_dx;
            r_s3_dy2  <= r_s2_dy * r_s2_dy;
        end
    end

endmodule

/* rtl/pta_rq.sv */
module pta_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pta_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output pta_pkg::t_result o_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    pta_pkg::t_result r_q [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

/* tb/pta_answer_checker.sv */
module pta_answer_checker #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  pta_pkg::t_cmd i_req,
    input  logic          i_empty,
    input  logic          i_pop,
    input  logic [1:0]    i_status,
    input  logic [15:0]   i_match_id,
    input  logic          i_last_result,
    output int            o_fail_count,
    output int            o_pending
);

    localparam logic KIND_STATIC  = 1'b0;
    localparam logic KIND_MOVABLE = 1'b1;
    localparam int   SHOWN_MAX    = 10;

    pta_pkg::t_entry  points [CAPACITY];
    int unsigned      n_points = 0;
    pta_pkg::t_result expected_answers [$];
    int               mismatches = 0;

    function automatic pta_pkg::t_result answer(input pta_pkg::t_status st,
                                                input logic [15:0] id,
                                                input logic last);
        pta_pkg::t_result r;
        r.status = st;
        r.id     = id;
        r.last   = last;
        return r;
    endfunction

    task automatic predict_answers(input pta_pkg::t_cmd c);
        logic [15:0]     hit_ids [pta_pkg::MAX_RESULTS];
        int unsigned     n_hits;
        logic            hit;
        longint          dx;
        longint          dy;
        pta_pkg::t_entry e;
        n_hits = 0;
        case (c.op)
            pta_pkg::OP_INS_STATIC, pta_pkg::OP_INS_MOVABLE: begin
                if (n_points >= CAPACITY) begin
                    expected_answers.push_back(answer(pta_pkg::ST_FULL, 16'h0, 1'b1));
                end else begin
                    e.kind  = (c.op == pta_pkg::OP_INS_MOVABLE) ? KIND_MOVABLE : KIND_STATIC;
                    e.id    = c.id;
                    e.x     = c.x;
                    e.y     = c.y;
                    e.angle = c.angle;
                    points[n_points] = e;
                    n_points++;
                    expected_answers.push_back(answer(pta_pkg::ST_INSERTED, 16'h0, 1'b1));
                end
            end
            pta_pkg::OP_RECT, pta_pkg::OP_CIRCLE, pta_pkg::OP_CIRCLE_ANGLE: begin
                for (int i = 0; i < n_points && n_hits < pta_pkg::MAX_RESULTS; i++) begin
                    e = points[i];
                    if (c.op == pta_pkg::OP_RECT) begin
                        hit = e.kind == KIND_STATIC
                            && $signed(e.x) >= $signed(c.xmin)
                            && $signed(e.x) <= $signed(c.xmax)
                            && $signed(e.y) >= $signed(c.ymin)
                            && $signed(e.y) <= $signed(c.ymax);
                    end else begin
                        dx  = longint'($signed(e.x)) - longint'($signed(c.x));
                        dy  = longint'($signed(e.y)) - longint'($signed(c.y));
                        hit = e.kind == KIND_MOVABLE
                            && dx * dx + dy * dy
                               <= longint'(c.radius) * longint'(c.radius);
                        if (c.op == pta_pkg::OP_CIRCLE_ANGLE) begin
                            hit = hit && $signed(e.angle) > $signed(c.amin)
                                      && $signed(e.angle) < $signed(c.amax);
                        end
                    end
                    if (hit) begin
                        hit_ids[n_hits] = e.id;
                        n_hits++;
                    end
                end
                if (n_hits == 0) begin
                    expected_answers.push_back(answer(pta_pkg::ST_NOMATCH, 16'h0, 1'b1));
                end else begin
                    for (int k = 0; k < n_hits; k++) begin
                        expected_answers.push_back(answer(pta_pkg::ST_MATCH, hit_ids[k],
                                                          k == n_hits - 1));
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        pta_pkg::t_result want;
        if (!i_rst_n) begin
            n_points = 0;
            expected_answers.delete();
        end else begin
            if (i_push && !i_full) begin
                predict_answers(i_req);
            end
            if (i_pop && !i_empty) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX) begin
                        $display("%0t: unexpected result: status %0d id %h last %0b",
                                 $time, i_status, i_match_id, i_last_result);
                    end
                end else begin
                    want = expected_answers.pop_front();
                    if (i_status !== want.status || i_match_id !== want.id
                        || i_last_result !== want.last) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX) begin
                            $display("%0t: mismatch: expected %0d/%h/%0b, got %0d/%h/%0b",
                                     $time, want.status, want.id, want.last,
                                     i_status, i_match_id, i_last_result);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_answers.size();
    end

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 180;
    localparam int UNUSED_OPS    = 3;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;

    localparam logic signed [15:0] MOST_NEG = 16'sh8000;
    localparam logic signed [15:0] MOST_POS = 16'sh7FFF;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          push;
    logic          full;
    logic          empty;
    logic          pop;
    pta_pkg::t_cmd req;
    logic [1:0]    status;
    logic [15:0]   match_id;
    logic          last_result;
    int            fail_count;
    int            pending;
    int unsigned   n_accepted  = 0;
    int unsigned   burst_left  = 0;
    int unsigned   idle_cycles = 0;
    logic          held_off    = 1'b0;

    wire progress = (push && !full) || (pop && !empty);

    always #1 clk = ~clk;

    point_table_area_query #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .push          (push),
        .full          (full),
        .i_operation   (req.op),
        .i_obj_id      (req.id),
        .i_point_x     (req.x),
        .i_point_y     (req.y),
        .i_obj_angle   (req.angle),
        .i_area_xmin   (req.xmin),
        .i_area_xmax   (req.xmax),
        .i_area_ymin   (req.ymin),
        .i_area_ymax   (req.ymax),
        .i_radius      (req.radius),
        .i_angle_min   (req.amin),
        .i_angle_max   (req.amax),
        .empty         (empty),
        .pop           (pop),
        .o_status      (status),
        .o_match_id    (match_id),
        .o_last_result (last_result)
    );

    pta_answer_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_req         (req),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_status      (status),
        .i_match_id    (match_id),
        .i_last_result (last_result),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // mostly within -2048..2047 so that queries hit, sometimes anywhere
    function automatic logic [15:0] coord();
        if ($urandom_range(4) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(4095) - 2048);
    endfunction

    function automatic logic [15:0] heading();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(2000) - 1000);
    endfunction

    function automatic pta_pkg::t_cmd noise_request(input pta_pkg::t_op op);
        pta_pkg::t_cmd c;
        c.op     = op;
        c.id     = 16'($urandom);
        c.x      = 16'($urandom);
        c.y      = 16'($urandom);
        c.angle  = 16'($urandom);
        c.xmin   = 16'($urandom);
        c.xmax   = 16'($urandom);
        c.ymin   = 16'($urandom);
        c.ymax   = 16'($urandom);
        c.radius = 16'($urandom);
        c.amin   = 16'($urandom);
        c.amax   = 16'($urandom);
        return c;
    endfunction

    function automatic pta_pkg::t_cmd random_request();
        pta_pkg::t_cmd c;
        pta_pkg::t_op  op;
        int unsigned   roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            op = pta_pkg::OP_INS_STATIC;
        end else if (roll < 20) begin
            op = pta_pkg::OP_INS_MOVABLE;
        end else if (roll < 45) begin
            op = pta_pkg::OP_RECT;
        end else if (roll < 70) begin
            op = pta_pkg::OP_CIRCLE;
        end else if (roll < 94) begin
            op = pta_pkg::OP_CIRCLE_ANGLE;
        end else begin
            op = pta_pkg::t_op'(pta_pkg::OP_CIRCLE_ANGLE + $urandom_range(UNUSED_OPS, 1));
        end
        c = noise_request(op);
        case (op)
            pta_pkg::OP_INS_STATIC, pta_pkg::OP_INS_MOVABLE: begin
                c.x     = coord();
                c.y     = coord();
                c.angle = heading();
            end
            pta_pkg::OP_RECT: begin
                if ($urandom_range(5) != 0) begin
                    c.xmin = coord();
                    c.xmax = c.xmin + 16'($urandom_range(3000));
                    c.ymin = coord();
                    c.ymax = c.ymin + 16'($urandom_range(3000));
                end
            end
            pta_pkg::OP_CIRCLE, pta_pkg::OP_CIRCLE_ANGLE: begin
                c.x = coord();
                c.y = coord();
                if ($urandom_range(7) != 0) begin
                    c.radius = 16'($urandom_range(3000));
                end
                if ($urandom_range(5) != 0) begin
                    c.amin = heading();
                    c.amax = c.amin + 16'($urandom_range(1500));
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send(input pta_pkg::t_cmd c);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req  <= c;
        push <= 1'b1;
        do @(posedge clk); while (full);
        n_accepted++;
    endtask

    initial begin
        pta_pkg::t_cmd c;
        int unsigned   n_real;
        rst_n <= 1'b0;
        push  <= 1'b0;
        req   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then the unused operation codes
        c = noise_request(pta_pkg::OP_RECT);
        c.xmin = MOST_NEG; c.xmax = MOST_POS; c.ymin = MOST_NEG; c.ymax = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE_ANGLE);
        c.radius = 16'hFFFF; c.amin = MOST_NEG; c.amax = MOST_POS;
        send(c);
        for (int k = 1; k <= UNUSED_OPS; k++) begin
            send(noise_request(pta_pkg::t_op'(pta_pkg::OP_CIRCLE_ANGLE + k)));
        end

        // points at the corners and the origin
        c = noise_request(pta_pkg::OP_INS_STATIC);
        c.id = 16'h0000; c.x = MOST_NEG; c.y = MOST_NEG;
        send(c);
        c = noise_request(pta_pkg::OP_INS_STATIC);
        c.id = 16'hFFFF; c.x = MOST_POS; c.y = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_INS_MOVABLE);
        c.x = MOST_NEG; c.y = MOST_POS; c.angle = MOST_NEG;
        send(c);
        c = noise_request(pta_pkg::OP_INS_MOVABLE);
        c.x = MOST_POS; c.y = MOST_NEG; c.angle = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_INS_MOVABLE);
        c.x = '0; c.y = '0; c.angle = '0;
        send(c);

        // rectangles: whole plane, single point, inverted, movable only
        c = noise_request(pta_pkg::OP_RECT);
        c.xmin = MOST_NEG; c.xmax = MOST_POS; c.ymin = MOST_NEG; c.ymax = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_RECT);
        c.xmin = MOST_POS; c.xmax = MOST_POS; c.ymin = MOST_POS; c.ymax = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_RECT);
        c.xmin = 16'sd1; c.xmax = -16'sd1; c.ymin = MOST_NEG; c.ymax = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_RECT);
        c.xmin = -16'sd1; c.xmax = 16'sd1; c.ymin = -16'sd1; c.ymax = 16'sd1;
        send(c);

        // circles: largest radius, zero radius, distance exactly on the edge
        c = noise_request(pta_pkg::OP_CIRCLE);
        c.x = '0; c.y = '0; c.radius = 16'hFFFF;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE);
        c.x = MOST_POS; c.y = MOST_NEG; c.radius = '0;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE);
        c.x = MOST_NEG; c.y = MOST_NEG; c.radius = 16'hFFFF;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE);
        c.x = MOST_NEG; c.y = MOST_NEG; c.radius = 16'hFFFE;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE);
        c.x = MOST_NEG; c.y = MOST_NEG; c.radius = '0;
        send(c);

        // angle bounds are strict
        c = noise_request(pta_pkg::OP_CIRCLE_ANGLE);
        c.x = '0; c.y = '0; c.radius = 16'hFFFF; c.amin = MOST_NEG; c.amax = MOST_POS;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE_ANGLE);
        c.x = '0; c.y = '0; c.radius = 16'hFFFF; c.amin = '0; c.amax = '0;
        send(c);
        c = noise_request(pta_pkg::OP_CIRCLE_ANGLE);
        c.x = '0; c.y = '0; c.radius = 16'hFFFF; c.amin = 16'sd5; c.amax = -16'sd5;
        send(c);

        n_real = 0;
        while (n_real < RANDOM_ITEMS) begin
            c = random_request();
            send(c);
            if (c.op <= pta_pkg::OP_CIRCLE_ANGLE) begin
                n_real++;
            end
        end
        push <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: rotating stall patterns, plus one long hold-off to back up the input
    initial begin
        int unsigned cyc;
        cyc = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!held_off && n_accepted >= HOLD_AFTER) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ((cyc / 64) % 4)
                0:       pop <= 1'b1;
                1:       pop <= (cyc % 3) != 0;
                2:       pop <= $urandom_range(1) == 1;
                default: pop <= ((cyc / 8) % 2) == 0;
            endcase
            cyc++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || progress) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
